### design/amtt_pkg.sv
// Shared types and constants of the tournament-tree argmax block.
package amtt_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDED_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDED_SECOND = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_ENTRIES  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RESET_EXCLUDED = 11'h7FF;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         entry_index;
        logic signed [31:0] weight_in;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic [9:0]         best_index;
        logic               best_valid;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_RB_INIT,
        ST_IDLE,
        ST_FETCH_CH,
        ST_FETCH_W,
        ST_COMBINE,
        ST_READ,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic accept;
        logic clr_step;
        logic rb_start;
        logic fetch_ch;
        logic fetch_w;
        logic combine;
        logic node_dec;
        logic node_half;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic cnt_zero;
        logic rb_req;
        logic is_write;
        logic walk_ok;
        logic node_last;
        logic out_busy;
    } ctrl_status_t;

endpackage

### design/amtt_ctrl.sv
// Controller state machine of the tournament-tree argmax block.
module amtt_ctrl
    import amtt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   rebuild_mode_reg, rebuild_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            rebuild_mode_reg <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            rebuild_mode_reg <= rebuild_mode_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        rebuild_mode_next = rebuild_mode_reg;
        cmd               = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_RB_INIT;
                end
            end
            ST_RB_INIT:
            begin
                cmd.rb_start      = 1'b1;
                rebuild_mode_next = 1'b1;
                state_next        = status.cnt_zero ? ST_IDLE : ST_FETCH_CH;
            end
            ST_IDLE:
            begin
                cmd.ready = !status.rb_req;
                if (status.rb_req)
                begin
                    state_next = ST_RB_INIT;
                end
                else if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_write && status.walk_ok)
                    begin
                        rebuild_mode_next = 1'b0;
                        state_next        = ST_FETCH_CH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FETCH_CH:
            begin
                cmd.fetch_ch = 1'b1;
                state_next   = ST_FETCH_W;
            end
            ST_FETCH_W:
            begin
                cmd.fetch_w = 1'b1;
                state_next  = ST_COMBINE;
            end
            ST_COMBINE:
            begin
                cmd.combine = 1'b1;
                if (status.node_last)
                begin
                    state_next = rebuild_mode_reg ? ST_IDLE : ST_READ;
                end
                else
                begin
                    cmd.node_dec  = rebuild_mode_reg;
                    cmd.node_half = !rebuild_mode_reg;
                    state_next    = ST_FETCH_CH;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### design/amtt_dpath.sv
// Datapath of the tournament-tree argmax block: weight and winner memories and node logic.
module amtt_dpath
    import amtt_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_word_t              item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  result_stall,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status,
    output logic                  result_valid,
    output out_word_t             result
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;
    localparam int KW = (NW > 10) ? NW : 10;
    localparam int XW = (IW > CFG_DATA_W) ? IW : CFG_DATA_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_ENTRIES - 1);

    typedef struct packed {
        logic          valid;
        logic [IW-1:0] idx;
    } win_t;

    // Memories.
    logic signed [31:0] weight_mem [MAX_ENTRIES];
    win_t               win_mem    [MAX_ENTRIES];

    logic [CFG_DATA_W-1:0] eiu_reg, exf_reg, exs_reg;
    logic                  rb_req_reg;
    logic [NW-1:0]         node_reg;
    logic [IW-1:0]         clr_addr_reg;
    logic [9:0]            key_reg;
    logic signed [31:0]    wa_rdata_reg, wb_rdata_reg, own_w_reg;
    win_t                  win_a_rdata_reg, win_b_rdata_reg, wl_reg, wr_reg;
    win_t                  root_reg;
    logic                  out_valid_reg;
    out_word_t             out_reg;

    logic [NW-1:0]  n_count;
    logic [NW:0]    child_l, child_r;
    logic [IW-1:0]  own_idx;
    logic [IW-1:0]  wa_addr;
    logic [KW-1:0]  key_ext, node_in;
    logic           key_in_range, key_reg_in_range;
    logic           cfg_hit;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic signed [31:0] mem_wdata;
    logic           own_ok, l_ok, r_ok;
    win_t           best_own, best_l, best_r;
    logic signed [31:0] w_own_sel, w_l_sel;
    logic [31:0]    idx_wide;
    logic [31:0]    key_wide;

    // Effective count, clipped to the array.
    always_comb
    begin
        if (CW'(eiu_reg) > MAX_C)
        begin
            n_count = NW'(MAX_ENTRIES);
        end
        else
        begin
            n_count = NW'(eiu_reg);
        end
    end

    assign key_ext      = KW'(item.entry_index);
    assign node_in      = key_ext + KW'(1);
    assign key_in_range = key_ext < KW'(MAX_ENTRIES);
    assign key_wide     = 32'(key_reg);
    assign key_reg_in_range = key_wide < 32'(MAX_ENTRIES);

    assign child_l = {node_reg, 1'b0};
    assign child_r = {node_reg, 1'b1};
    assign own_idx = IW'(node_reg - NW'(1));

    // Status to the controller.
    always_comb
    begin
        status           = '0;
        status.clr_last  = clr_addr_reg == LAST_ADDR;
        status.cnt_zero  = n_count == '0;
        status.rb_req    = rb_req_reg;
        status.is_write  = item.cmd == CMD_WRITE;
        status.walk_ok   = key_in_range && (node_in <= KW'(n_count));
        status.node_last = node_reg == NW'(1);
        status.out_busy  = out_valid_reg && result_stall;
    end

    // Any write to a known register asks for a rebuild.
    assign cfg_hit = cfg_we && ((cfg_index == CFG_ENTRIES_IN_USE) ||
                                (cfg_index == CFG_EXCLUDED_FIRST) ||
                                (cfg_index == CFG_EXCLUDED_SECOND));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg    <= RESET_ENTRIES;
            exf_reg    <= RESET_EXCLUDED;
            exs_reg    <= RESET_EXCLUDED;
            rb_req_reg <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                rb_req_reg <= 1'b1;
            end
            else if (cmd.rb_start)
            begin
                rb_req_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENTRIES_IN_USE:
                    begin
                        eiu_reg <= cfg_data;
                    end
                    CFG_EXCLUDED_FIRST:
                    begin
                        exf_reg <= cfg_data;
                    end
                    CFG_EXCLUDED_SECOND:
                    begin
                        exs_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            node_reg     <= '0;
            root_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + IW'(1);
            end
            if (cmd.rb_start)
            begin
                node_reg <= n_count;
                root_reg <= '0;
            end
            else if (cmd.accept)
            begin
                node_reg <= NW'(node_in);
            end
            else if (cmd.node_dec)
            begin
                node_reg <= node_reg - NW'(1);
            end
            else if (cmd.node_half)
            begin
                node_reg <= node_reg >> 1;
            end
            if (cmd.combine && node_reg == NW'(1))
            begin
                root_reg <= best_r;
            end
        end
    end

    // Accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= item.entry_index;
        end
    end

    // Weight memory: one write port, two registered read ports.
    assign mem_we    = cmd.clr_step || (cmd.accept && item.cmd == CMD_WRITE && key_in_range);
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : IW'(item.entry_index);
    assign mem_wdata = cmd.clr_step ? 32'sd0 : item.weight_in;

    always_comb
    begin
        if (cmd.fetch_ch)
        begin
            wa_addr = own_idx;
        end
        else if (cmd.fetch_w)
        begin
            wa_addr = win_a_rdata_reg.idx;
        end
        else
        begin
            wa_addr = IW'(key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            weight_mem[mem_waddr] <= mem_wdata;
        end
        wa_rdata_reg <= weight_mem[wa_addr];
        wb_rdata_reg <= weight_mem[win_b_rdata_reg.idx];
    end

    // Winner memory, addressed by node number minus one.
    always_ff @(posedge clk)
    begin
        if (cmd.combine)
        begin
            win_mem[own_idx] <= best_r;
        end
        win_a_rdata_reg <= win_mem[IW'(child_l - (NW + 1)'(1))];
        win_b_rdata_reg <= win_mem[IW'(child_r - (NW + 1)'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_w)
        begin
            own_w_reg <= wa_rdata_reg;
            wl_reg    <= win_a_rdata_reg;
            wr_reg    <= win_b_rdata_reg;
        end
    end

    // Node combine: own entry first, then left, then right on strict greater.
    always_comb
    begin
        own_ok = !((!exf_reg[CFG_DATA_W-1]) && (XW'(own_idx) == XW'(exf_reg))) &&
                 !((!exs_reg[CFG_DATA_W-1]) && (XW'(own_idx) == XW'(exs_reg)));
        best_own.valid = own_ok;
        best_own.idx   = own_ok ? own_idx : '0;
        w_own_sel      = own_w_reg;

        l_ok = (child_l <= (NW + 1)'(n_count)) && wl_reg.valid;
        if (l_ok && (!best_own.valid || (wa_rdata_reg > w_own_sel)))
        begin
            best_l  = wl_reg;
            w_l_sel = wa_rdata_reg;
        end
        else
        begin
            best_l  = best_own;
            w_l_sel = w_own_sel;
        end

        r_ok = (child_r <= (NW + 1)'(n_count)) && wr_reg.valid;
        if (r_ok && (!best_l.valid || (wb_rdata_reg > w_l_sel)))
        begin
            best_r = wr_reg;
        end
        else
        begin
            best_r = best_l;
        end
    end

    // Output register.
    assign idx_wide = 32'(root_reg.idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.weight_out <= key_reg_in_range ? wa_rdata_reg : 32'sd0;
            if (n_count != '0 && root_reg.valid)
            begin
                out_reg.best_index <= idx_wide[9:0];
                out_reg.best_valid <= 1'b1;
            end
            else
            begin
                out_reg.best_index <= '0;
                out_reg.best_valid <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### design/argmax_tournament_tree_excluding_two.sv
// Top level of the tournament-tree argmax block with two excluded entries.
//
// The block keeps MAX_ENTRIES signed Q16.16 weights and a heap-shaped tree whose
// node n holds the winner of its subtree. An input word either writes a weight
// (cmd 0) or reads one (cmd 1); each word yields one result word carrying the
// addressed weight, the index of the largest non-excluded entry and a valid flag.
// Both channels use valid and stall; a word moves when valid is high and stall low.
// A read, or a write to an entry outside the tree, passes through the read and
// result states into the result register, and the next word is taken only once
// that register has been loaded. A write inside the tree walks from its node to the
// root, each tree level taking two memory reads and one combine, and then passes
// through the same read and result states; no word is taken before it is done.
// After reset the weight memory is cleared entry by entry, all MAX_ENTRIES of them,
// then the tree is rebuilt bottom-up, one node in use after another; the same
// rebuild follows each configuration write to a known register. No word is taken
// during either pass.
// The result sits in an output register, so a new word is accepted while the
// previous result is still stalled; the next result waits until that one is taken.
module argmax_tournament_tree_excluding_two
    import amtt_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_word_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_word_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Words are only taken by the controller when it is idle and no rebuild waits.
    assign item_stall = !cmd.ready;

    amtt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .status     (status),
        .cmd        (cmd)
    );

    amtt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench of the tournament-tree argmax block.
`timescale 1ns / 100ps

module testbench;
    import amtt_pkg::*;

    localparam int DEPTH = 1024;

    // After a configuration write the block clears nothing but rebuilds the tree node
    // by node over the nodes in use; the settle below covers a full array plus margin.
    localparam int REBUILD_WAIT = 3 * DEPTH + 200;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    in_word_t    item;
    logic        result_valid;
    logic        result_stall;
    out_word_t   result;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    argmax_tournament_tree_excluding_two uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state: the weight bank, the per-node winners and the three registers.
    logic signed [31:0] bank [DEPTH];
    logic [9:0]         node_best [DEPTH + 2];
    logic               node_ok [DEPTH + 2];
    logic [10:0]        in_use;
    logic [10:0]        skip_a;
    logic [10:0]        skip_b;

    out_word_t expected_words [$];
    int        mismatches;
    int        results_seen;
    bit        quiet_phase;
    bit        hold_result;

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int live_count();
        return (in_use > DEPTH) ? DEPTH : int'(in_use);
    endfunction

    // An exclusion register with its sign bit set names no entry.
    function automatic bit skipped(int idx);
        return (!skip_a[10] && idx == int'(skip_a)) || (!skip_b[10] && idx == int'(skip_b));
    endfunction

    function automatic void settle_node(int node, int n);
        int kid;
        if (!skipped(node - 1))
        begin
            node_best[node] = 10'(node - 1);
            node_ok[node]   = 1'b1;
        end
        else
        begin
            node_best[node] = '0;
            node_ok[node]   = 1'b0;
        end
        // Own entry first, then left child, then right child: strictly greater wins.
        for (kid = 2 * node; kid <= 2 * node + 1; kid++)
        begin
            if (kid <= n && node_ok[kid])
            begin
                if (!node_ok[node] || bank[node_best[kid]] > bank[node_best[node]])
                begin
                    node_best[node] = node_best[kid];
                    node_ok[node]   = 1'b1;
                end
            end
        end
    endfunction

    function automatic void regrow_tree();
        int n;
        n = live_count();
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            node_best[i] = '0;
            node_ok[i]   = 1'b0;
        end
        for (int i = n; i >= 1; i--)
            settle_node(i, n);
    endfunction

    // Works out the result word of one accepted input word and updates the state.
    function automatic out_word_t argmax_after(in_word_t w);
        out_word_t r;
        int n;
        int node;
        n = live_count();
        if (w.cmd == CMD_WRITE)
        begin
            bank[w.entry_index] = w.weight_in;
            node = int'(w.entry_index) + 1;
            if (node <= n)
            begin
                while (node > 0)
                begin
                    settle_node(node, n);
                    node = node >> 1;
                end
            end
        end
        r.weight_out = bank[w.entry_index];
        if (n >= 1 && node_ok[1])
        begin
            r.best_index = node_best[1];
            r.best_valid = 1'b1;
        end
        else
        begin
            r.best_index = '0;
            r.best_valid = 1'b0;
        end
        return r;
    endfunction

    // Directed rows. A known result is typed in only where it is obvious; the rest
    // goes through the predictor.
    typedef struct {
        in_word_t  w;
        bit        known;
        out_word_t res;
    } row_t;

    row_t rows [$];

    function automatic in_word_t mk(logic c, int idx, logic signed [31:0] wt);
        in_word_t w;
        w.cmd         = c;
        w.entry_index = 10'(idx);
        w.weight_in   = wt;
        return w;
    endfunction

    function automatic out_word_t mkr(logic signed [31:0] wt, int bi, logic bv);
        out_word_t r;
        r.weight_out = wt;
        r.best_index = 10'(bi);
        r.best_valid = bv;
        return r;
    endfunction

    function automatic void add_row(in_word_t w, bit known, out_word_t r);
        row_t x;
        x.w     = w;
        x.known = known;
        x.res   = r;
        rows.push_back(x);
    endfunction

    // Push one word across the input channel, with random idle bursts.
    task automatic offer_word(in_word_t w, bit known, out_word_t r);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // Accepted at this edge: predict now, override with the typed-in value if any.
        begin
            out_word_t p;
            p = argmax_after(w);
            expected_words.push_back(known ? r : p);
        end
    endtask

    task automatic lower_valid();
        item_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        lower_valid();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Configuration writes only happen with the block idle; each one is followed by
    // a pause long enough for the rebuild.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENTRIES_IN_USE:  in_use = val;
            CFG_EXCLUDED_FIRST:  skip_a = val;
            CFG_EXCLUDED_SECOND: skip_b = val;
            default: ;
        endcase
        regrow_tree();
        repeat (REBUILD_WAIT) @(posedge clk);
    endtask

    // Random traffic; most indices fall within the live count so that the tree walk
    // is exercised, with a few spread over the whole range.
    task automatic random_words(int count);
        in_word_t w;
        int n;
        out_word_t dummy;
        dummy = '0;
        for (int k = 0; k < count; k++)
        begin
            n = live_count();
            w.cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_WRITE;
            if (n > 0 && $urandom_range(0, 9) != 0)
                w.entry_index = 10'($urandom_range(0, n - 1));
            else
                w.entry_index = 10'($urandom);
            case ($urandom_range(0, 5))
                0: w.weight_in = 32'sh7FFF_FFFF;
                1: w.weight_in = 32'sh8000_0000;
                2: w.weight_in = 32'($signed($urandom_range(0, 15)) - 8);
                default: w.weight_in = $urandom;
            endcase
            offer_word(w, 1'b0, dummy);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, none in the quiet phase.
    initial begin
        int burst;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_result)
            begin
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                result_stall <= 1'b0;
                hold_result = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                burst = $urandom_range(1, 8);
                repeat (burst) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                e = expected_words.pop_front();
                if (result.weight_out !== e.weight_out || result.best_index !== e.best_index
                    || result.best_valid !== e.best_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: weight %h/%h index %0d/%0d valid %b/%b",
                                 e.weight_out, result.weight_out, e.best_index,
                                 result.best_index, e.best_valid, result.best_valid);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        out_word_t z;
        z            = '0;
        mismatches   = 0;
        results_seen = 0;
        quiet_phase  = 1'b0;
        hold_result  = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ENTRIES_IN_USE;
        cfg_data     = '0;
        for (int i = 0; i < DEPTH; i++)
            bank[i] = '0;
        in_use = RESET_ENTRIES;
        skip_a = RESET_EXCLUDED;
        skip_b = RESET_EXCLUDED;
        regrow_tree();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. After reset all weights are zero, so the root holds entry 0.
        add_row(mk(CMD_READ, 0, 0), 1'b1, mkr(0, 0, 1'b1));
        add_row(mk(CMD_READ, 1023, 0), 1'b1, mkr(0, 0, 1'b1));
        add_row(mk(CMD_WRITE, 1023, 32'sh7FFF_FFFF), 1'b1, mkr(32'sh7FFF_FFFF, 1023, 1'b1));
        add_row(mk(CMD_WRITE, 0, 32'sh8000_0000), 1'b0, z);
        add_row(mk(CMD_WRITE, 512, 32'sh7FFF_FFFF), 1'b0, z);
        add_row(mk(CMD_WRITE, 1023, -1), 1'b0, z);
        add_row(mk(CMD_WRITE, 5, 32'sh0001_0000), 1'b0, z);
        add_row(mk(CMD_READ, 5, 32'h5555_5555), 1'b0, z);
        add_row(mk(CMD_WRITE, 6, 32'sh0001_0000), 1'b0, z);
        add_row(mk(CMD_WRITE, 2, 32'sh0001_0000), 1'b0, z);
        add_row(mk(CMD_WRITE, 512, 32'sh8000_0000), 1'b0, z);
        add_row(mk(CMD_WRITE, 341, 32'shAAAA_AAAA), 1'b0, z);
        add_row(mk(CMD_WRITE, 682, 32'sh5555_5555), 1'b0, z);
        add_row(mk(CMD_READ, 682, 0), 1'b0, z);
        add_row(mk(CMD_READ, 341, -1), 1'b0, z);
        // Waiting for the reset clearing pass and rebuild: first word just queues.
        foreach (rows[i])
            offer_word(rows[i].w, rows[i].known, rows[i].res);
        wait_drained();

        // Exclude the current winner, then entry 1023 too, so that both exclusions hold at once.
        write_reg(CFG_EXCLUDED_FIRST, 11'd682);
        offer_word(mk(CMD_READ, 0, 0), 1'b0, z);
        wait_drained();
        write_reg(CFG_EXCLUDED_SECOND, 11'd1023);
        offer_word(mk(CMD_READ, 2, 0), 1'b0, z);
        offer_word(mk(CMD_WRITE, 1023, 32'sh7FFF_FFFF), 1'b0, z);
        wait_drained();

        // Count of zero gives an empty tree; writes still land in the bank.
        write_reg(CFG_ENTRIES_IN_USE, 11'd0);
        offer_word(mk(CMD_WRITE, 3, 32'sh0000_0100), 1'b1, mkr(32'sh0000_0100, 0, 1'b0));
        offer_word(mk(CMD_READ, 3, 0), 1'b1, mkr(32'sh0000_0100, 0, 1'b0));
        wait_drained();

        // One entry, excluded: no winner at all.
        write_reg(CFG_ENTRIES_IN_USE, 11'd1);
        write_reg(CFG_EXCLUDED_FIRST, 11'd0);
        offer_word(mk(CMD_WRITE, 0, 32'sh7FFF_FFFF), 1'b1, mkr(32'sh7FFF_FFFF, 0, 1'b0));
        wait_drained();

        // Count above the array acts as the full array; one exclusion off, one on entry 1023.
        write_reg(CFG_ENTRIES_IN_USE, 11'h7FF);
        write_reg(CFG_EXCLUDED_FIRST, 11'h400);
        write_reg(CFG_EXCLUDED_SECOND, 11'd1024 - 1);
        random_words(300);
        wait_drained();

        // Small tree with an exclusion beyond the count: mostly shallow traffic.
        write_reg(CFG_ENTRIES_IN_USE, 11'd7);
        write_reg(CFG_EXCLUDED_FIRST, 11'd3);
        write_reg(CFG_EXCLUDED_SECOND, 11'd900);
        // Long receiver hold-off while words keep coming, to fill the block.
        hold_result = 1'b1;
        random_words(400);
        wait_drained();

        write_reg(CFG_ENTRIES_IN_USE, 11'd2);
        write_reg(CFG_EXCLUDED_FIRST, 11'h7FF);
        write_reg(CFG_EXCLUDED_SECOND, 11'd1);
        random_words(200);
        wait_drained();

        write_reg(CFG_ENTRIES_IN_USE, 11'd1000);
        write_reg(CFG_EXCLUDED_FIRST, 11'd0);
        write_reg(CFG_EXCLUDED_SECOND, 11'd999);
        random_words(400);

        // Last stretch without idling on either side.
        quiet_phase = 1'b1;
        random_words(300);
        wait_drained();
        repeat (100) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
